@@ hw/rtl/bdr_pkg.sv @@
// Shared constants and codes for the bus device registry.
`default_nettype none

package bdr_pkg;

  // Default table depth
  localparam int MAX_DEVICES_DEF = 16;

  // Widths fixed by the item fields
  localparam int REQ_W    = 2;
  localparam int DEV_W    = 8;
  localparam int RXID_W   = 29;
  localparam int MASK_W   = 16;
  localparam int STATUS_W = 3;
  localparam int EIDX_W   = 4;

  // Reset value of the id clear mask
  localparam logic [RXID_W-1:0] ID_CLEAR_MASK_RST = 29'h1FFF_FFC0;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TURN     = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IN_USE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd6;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_TURN   = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bus_device_registry_round_robin_unit.sv @@
// Bus device registry: id table in memory, lookup scan and round-robin turns.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, req_type, dev_id,           | to block
//          | claims_unique, rx_id, active_mask, pending_mask |
//  out     | out_valid, out_ready, status, entry_index,      | from block
//          | send_grant                                      |
//  cfg     | cfg_we, cfg_data (id clear mask)                | to block
//
// Register and lookup requests scan the id memory one entry a cycle through
// its single read port. Transmit turns step through the active bits one
// entry a cycle. Reset clears the entry count, the turn pointer and the
// output valid flag, and restores the clear mask; the id memory is not
// cleared. A new item is taken while a result still waits in the output
// register; the sequencer holds in its final state until that register is
// free.
`default_nettype none

module bus_device_registry_round_robin_unit
  import bdr_pkg::*;
#(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [REQ_W-1:0]    req_type,
  input  wire logic [DEV_W-1:0]    dev_id,
  input  wire logic                claims_unique,
  input  wire logic [RXID_W-1:0]   rx_id,
  input  wire logic [MASK_W-1:0]   active_mask,
  input  wire logic [MASK_W-1:0]   pending_mask,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [EIDX_W-1:0]        entry_index,
  output logic                     send_grant,
  input  wire logic                cfg_we,
  input  wire logic [RXID_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_DEVICES + 1);
  localparam int IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DEVICES);

  // Id table memory
  logic [DEV_W-1:0] mem [MAX_DEVICES];
  logic [DEV_W-1:0] rdata;

  state_t state;
  logic [RXID_W-1:0] clr_mask;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;

  // Held item
  logic [REQ_W-1:0]  req;
  logic [DEV_W-1:0]  key;
  logic              srch_en;
  logic [DEV_W-1:0]  dev;
  logic [MASK_W-1:0] act;
  logic [MASK_W-1:0] pend;

  // Scan state
  logic [CW-1:0] scan_idx;
  logic          rd_pend;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] cur;
  logic [CW-1:0] steps;
  logic [CW-1:0] base;

  // Pending result and state update
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]       res_idx;
  logic                res_grant;
  logic                res_append;
  logic                res_ptr_upd;
  logic [CW-1:0]       res_ptr;

  logic            accept;
  logic            out_free;
  logic            hit;
  logic            rd_issue;
  logic [MASK_W-1:0] act_sh;
  logic [MASK_W-1:0] pend_sh;
  logic [CW:0]     cur_inc;
  logic [CW-1:0]   cur_next;
  logic [CW-1:0]   base_next;
  logic [CW+EIDX_W-1:0] idx_ext;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Compare the returned entry against the key
  assign hit      = (state == S_SEARCH) && rd_pend && srch_en && (rdata == key);
  assign rd_issue = (state == S_SEARCH) && !hit && (scan_idx < count);

  // Active and pending bits of the current entry; entries past the mask read 0
  assign act_sh   = act >> cur;
  assign pend_sh  = pend >> cur;
  assign cur_inc  = {1'b0, cur} + 1'b1;
  assign cur_next = (cur_inc == {1'b0, count}) ? '0 : cur_inc[CW-1:0];

  // Wrap the pointer at the count before the turn
  assign base_next = (ptr >= count) ? '0 : ptr;

  assign idx_ext = {{EIDX_W{1'b0}}, res_idx};

  // Read the id memory
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rdata <= mem[scan_idx[IW-1:0]];
    end
  end

  // Append a registered id
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free && res_append) begin
      mem[count[IW-1:0]] <= dev;
    end
  end

  // Hold the id clear mask
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_mask <= ID_CLEAR_MASK_RST;
    end else if (cfg_we) begin
      clr_mask <= cfg_data;
    end
  end

  // Sequence one item through scan and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req         <= req_type;
            dev         <= dev_id;
            act         <= active_mask;
            pend        <= pending_mask;
            srch_en     <= (req_type == REQ_LOOKUP) || claims_unique;
            key         <= (req_type == REQ_LOOKUP) ? rx_id[DEV_W-1:0] & ~clr_mask[DEV_W-1:0]
                                                    : dev_id;
            scan_idx    <= '0;
            rd_pend     <= 1'b0;
            res_status  <= ST_OK;
            res_idx     <= '0;
            res_grant   <= 1'b0;
            res_append  <= 1'b0;
            res_ptr_upd <= 1'b0;
            res_ptr     <= '0;
            if (req_type == REQ_REGISTER || req_type == REQ_LOOKUP) begin
              state <= S_SEARCH;
            end else if (req_type == REQ_TURN) begin
              if (count == '0) begin
                res_status <= ST_NONE;
                state      <= S_DONE;
              end else begin
                base  <= base_next;
                cur   <= base_next;
                steps <= '0;
                state <= S_TURN;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          rd_pend <= rd_issue;
          rd_idx  <= scan_idx;
          if (rd_issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          priority if (hit) begin
            res_idx    <= rd_idx;
            res_status <= (req == REQ_REGISTER) ? ST_IN_USE : ST_OK;
            state      <= S_DONE;
          end else if (!rd_pend && (scan_idx >= count)) begin
            if (req == REQ_LOOKUP) begin
              res_status <= ST_NO_MATCH;
            end else if (count >= MAX_CNT) begin
              res_status <= ST_FULL;
            end else begin
              res_idx    <= count;
              res_append <= 1'b1;
            end
            state <= S_DONE;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_TURN: begin
          priority if (act_sh[0]) begin
            res_idx     <= cur;
            res_grant   <= pend_sh[0];
            res_status  <= pend_sh[0] ? ST_OK : ST_EMPTY;
            res_ptr_upd <= 1'b1;
            res_ptr     <= cur_inc[CW-1:0];
            state       <= S_DONE;
          end else if (steps == count - 1'b1) begin
            res_idx     <= base;
            res_status  <= ST_INACTIVE;
            res_ptr_upd <= 1'b1;
            res_ptr     <= base;
            state       <= S_DONE;
          end else begin
            cur   <= cur_next;
            steps <= steps + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            entry_index <= idx_ext[EIDX_W-1:0];
            send_grant  <= res_grant;
            if (res_append) begin
              count <= count + 1'b1;
            end
            if (res_ptr_upd) begin
              ptr <= res_ptr;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
